>>> rtl/mexp_pkg.sv
// Package with the shared types and constants of the modular exponentiation block.
package mexp_pkg;

  // The result field is never wider than this many bits.
  localparam int RESULT_BITS = 32;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_REDUCE,
    ST_BIT,
    ST_MUL,
    ST_SQR,
    ST_FIN
  } state_t;

  // Operand selection for the modular multiplier.
  typedef enum logic [1:0] {
    MM_REDUCE,
    MM_MUL,
    MM_SQR
  } mm_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   load;
    logic   mm_start;
    mm_op_t mm_op;
    logic   mm_step;
    logic   wr_base;
    logic   wr_acc;
    logic   exp_shift;
    logic   out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic m_zero;
    logic exp_bit;
    logic exp_rest_zero;
    logic mm_done;
  } status_t;

endpackage

>>> rtl/mexp_if.sv
// Valid/ready channel interfaces for the operand and result transfers.
interface mexp_in_if #(
  parameter int WIDTH = 32
) ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] base_value;
  logic [WIDTH-1:0] exponent;
  logic [WIDTH-1:0] modulus;

  modport source (output valid, output base_value, output exponent, output modulus,
                  input ready);
  modport sink (input valid, input base_value, input exponent, input modulus,
                output ready);
endinterface

interface mexp_out_if #(
  parameter int WIDTH = 32
) ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] power_result;
  logic             bad_modulus;

  modport source (output valid, output power_result, output bad_modulus, input ready);
  modport sink (input valid, input power_result, input bad_modulus, output ready);
endinterface

>>> rtl/mexp_dp.sv
// Datapath: operand registers, iterative modular multiplier and result register.
module mexp_dp #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [WIDTH-1:0]   in_base_value,
  input  logic [WIDTH-1:0]   in_exponent,
  input  logic [WIDTH-1:0]   in_modulus,
  input  mexp_pkg::cmd_t     cmd,
  output mexp_pkg::status_t  status,
  output logic [WIDTH-1:0]   out_power_result,
  output logic               out_bad_modulus
);
  import mexp_pkg::*;

  localparam int CntW     = $clog2(WIDTH);
  localparam int KeepBits = (WIDTH < RESULT_BITS) ? WIDTH : RESULT_BITS;

  // (x + y) mod m for x, y below m.
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH:0]   s;
    logic [WIDTH+1:0] d;
    s = {1'b0, x} + {1'b0, y};
    d = {1'b0, s} - {2'b00, m};
    add_mod = d[WIDTH+1] ? s[WIDTH-1:0] : d[WIDTH-1:0];
  endfunction

  logic [WIDTH-1:0] m_r;
  logic [WIDTH-1:0] e_r;
  logic [WIDTH-1:0] base_r;
  logic [WIDTH-1:0] acc_r;
  logic             zero_exp_r;

  logic [WIDTH-1:0] mm_acc_r;
  logic [WIDTH-1:0] mm_a_r;
  logic [WIDTH-1:0] mm_b_r;
  logic [CntW-1:0]  cnt_r;
  logic             half_r;

  logic [WIDTH-1:0] power_r;
  logic             bad_r;

  logic [WIDTH-1:0] keep_mask;
  logic [WIDTH-1:0] mm_addend;
  logic [WIDTH-1:0] mm_sum;
  logic             mm_last_bit;

  assign keep_mask   = {WIDTH{1'b1}} >> (WIDTH - KeepBits);
  assign mm_addend   = half_r ? mm_a_r : mm_acc_r;
  assign mm_sum      = add_mod(mm_acc_r, mm_addend, m_r);
  assign mm_last_bit = (cnt_r == CntW'(WIDTH - 1));

  // Status toward the controller.
  assign status.m_zero        = (m_r == '0);
  assign status.exp_bit       = e_r[0];
  assign status.exp_rest_zero = (e_r[WIDTH-1:1] == '0);
  assign status.mm_done       = mm_last_bit && (half_r || !mm_b_r[WIDTH-1]);

  // Operand registers and running values of the square-and-multiply loop.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_r        <= in_modulus;
      e_r        <= in_exponent;
      base_r     <= in_base_value;
      zero_exp_r <= (in_exponent == '0);
      acc_r      <= (in_modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
    end else begin
      if (cmd.wr_base) begin
        base_r <= mm_sum;
      end
      if (cmd.wr_acc) begin
        acc_r <= mm_sum;
      end
      if (cmd.exp_shift) begin
        e_r <= e_r >> 1;
      end
    end
  end

  // Interleaved shift-and-add modular multiplier: one double or one add a cycle.
  always_ff @(posedge clk) begin
    if (cmd.mm_start) begin
      mm_acc_r <= '0;
      cnt_r    <= '0;
      half_r   <= 1'b0;
      case (cmd.mm_op)
        MM_REDUCE: begin
          mm_a_r <= WIDTH'(1);
          mm_b_r <= base_r;
        end
        MM_MUL: begin
          mm_a_r <= acc_r;
          mm_b_r <= base_r;
        end
        MM_SQR: begin
          mm_a_r <= base_r;
          mm_b_r <= base_r;
        end
        default: begin
          mm_a_r <= '0;
          mm_b_r <= '0;
        end
      endcase
    end else if (cmd.mm_step) begin
      mm_acc_r <= mm_sum;
      if (!half_r && mm_b_r[WIDTH-1]) begin
        half_r <= 1'b1;
      end else begin
        half_r <= 1'b0;
        mm_b_r <= mm_b_r << 1;
        cnt_r  <= cnt_r + CntW'(1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      bad_r <= (m_r == '0);
      if (m_r == '0) begin
        power_r <= '0;
      end else if (zero_exp_r) begin
        power_r <= WIDTH'(1);
      end else begin
        power_r <= acc_r & keep_mask;
      end
    end
  end

  assign out_power_result = power_r;
  assign out_bad_modulus  = bad_r;

  // The multiplier's running value stays reduced.
  a_mm_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mm_step |-> (mm_acc_r < m_r))
    else $error("multiplier accumulator not reduced");

  // A new base is always below the modulus.
  a_base_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_base |=> (base_r < m_r))
    else $error("base not reduced");

  // A new running result is always below the modulus.
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_acc |=> (acc_r < m_r))
    else $error("running result not reduced");

endmodule

>>> rtl/mexp_ctrl.sv
// Controller state machine: sequences reduction, multiplies, squares and the output transfer.
module mexp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  mexp_pkg::status_t  status,
  output mexp_pkg::cmd_t     cmd
);
  import mexp_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        state_nxt = status.m_zero ? ST_FIN : ST_REDUCE;
      end
      ST_REDUCE: begin
        if (status.mm_done) begin
          state_nxt = ST_BIT;
        end
      end
      ST_BIT: begin
        if (status.exp_bit) begin
          state_nxt = ST_MUL;
        end else if (status.exp_rest_zero) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_SQR;
        end
      end
      ST_MUL: begin
        if (status.mm_done) begin
          state_nxt = status.exp_rest_zero ? ST_FIN : ST_SQR;
        end
      end
      ST_SQR: begin
        if (status.mm_done) begin
          state_nxt = ST_BIT;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    cmd.mm_op = MM_REDUCE;
    case (state_r)
      ST_IDLE: begin
        cmd.load = in_valid;
      end
      ST_START: begin
        if (!status.m_zero) begin
          cmd.mm_start = 1'b1;
          cmd.mm_op    = MM_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.mm_step = 1'b1;
        cmd.wr_base = status.mm_done;
      end
      ST_BIT: begin
        if (status.exp_bit) begin
          cmd.mm_start = 1'b1;
          cmd.mm_op    = MM_MUL;
        end else if (!status.exp_rest_zero) begin
          cmd.mm_start  = 1'b1;
          cmd.mm_op     = MM_SQR;
          cmd.exp_shift = 1'b1;
        end
      end
      ST_MUL: begin
        cmd.mm_step = 1'b1;
        if (status.mm_done) begin
          cmd.wr_acc = 1'b1;
          if (!status.exp_rest_zero) begin
            cmd.mm_start  = 1'b1;
            cmd.mm_op     = MM_SQR;
            cmd.exp_shift = 1'b1;
          end
        end
      end
      ST_SQR: begin
        cmd.mm_step = 1'b1;
        cmd.wr_base = status.mm_done;
      end
      ST_FIN: begin
        cmd.out_load = out_free;
      end
      default: cmd = '0;
    endcase
  end

  // Output valid flag: set by a result load, cleared by the output transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // An accepted item always starts processing in the next cycle.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_START))
    else $error("accepted item did not start");

  // A finished item waits while the output register is still occupied.
  a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !out_free) |=> (state_r == ST_FIN && out_valid_r))
    else $error("finished item lost while output stalled");

  // A result is loaded only when the output register is free.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result overwrote a pending output");

endmodule

>>> rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block: controller plus datapath.
//
// Usage: an operand transfer on in_ch carries base_value, exponent and modulus;
// each one yields exactly one result transfer on out_ch with power_result and
// bad_modulus. Both channels use valid/ready; a transfer happens at a rising
// clock edge with valid and ready high.
// One item is processed at a time. The base is first reduced by the modulus
// (ST_REDUCE); then each exponent bit passes the decision state ST_BIT, a
// multiply (ST_MUL) when the bit is set and a square (ST_SQR) while higher bits
// remain. The modular multiplier does one modular double or add per cycle.
// A zero modulus skips the reduction and the loop and goes straight to ST_FIN.
// The next operand transfer can follow once a result has been loaded.
// The result sits in an output register, so a new item is accepted while the
// previous result still waits; a finished item holds until that register frees.
// A zero modulus gives bad_modulus = 1 and power_result = 0.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// out_ch.valid; no other initialization is needed.
module modular_exponentiation #(
  parameter int WIDTH = 32
) (
  input logic        clk,
  input logic        rst_n,
  mexp_in_if.sink    in_ch,
  mexp_out_if.source out_ch
);
  import mexp_pkg::*;

  cmd_t    cmd;
  status_t status;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mexp_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_base_value    (in_ch.base_value),
    .in_exponent      (in_ch.exponent),
    .in_modulus       (in_ch.modulus),
    .cmd              (cmd),
    .status           (status),
    .out_power_result (out_ch.power_result),
    .out_bad_modulus  (out_ch.bad_modulus)
  );

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the modular exponentiation block with valid/ready channels.
module tb;

  localparam int WIDTH       = 32;
  localparam int IDLE_LIMIT  = 20000;
  localparam int TAIL_CYCLES = 60;
  localparam int RANDOM_JOBS = 120;

  // One operand set, with the pacing the sender applies before offering it.
  typedef struct {
    logic [WIDTH-1:0] base_value;
    logic [WIDTH-1:0] exponent;
    logic [WIDTH-1:0] modulus;
    int unsigned      gap;
    bit               drain_first;
    bit               quiet;
  } operand_set_t;

  // One expected result transfer.
  typedef struct {
    logic [WIDTH-1:0] power;
    logic             bad;
  } power_t;

  logic clk;
  logic rst_n;

  mexp_in_if  #(.WIDTH(WIDTH)) in_ch ();
  mexp_out_if #(.WIDTH(WIDTH)) out_ch ();

  modular_exponentiation #(.WIDTH(WIDTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  operand_set_t operand_sets[$];
  power_t       pending_powers[$];
  operand_set_t staged_set;
  operand_set_t offered_set;
  bit           staged;
  int unsigned  gap_left;
  int unsigned  stall_left;
  int unsigned  idle_cycles;
  int unsigned  total_sets;
  int unsigned  sets_sent;
  int unsigned  results_checked;
  int unsigned  zero_modulus_sets;
  int unsigned  zero_exponent_sets;
  int unsigned  error_count;
  logic         sink_quiet;

  // Free-running clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Expected result: right-to-left square-and-multiply with exact 64-bit products.
  function automatic power_t mod_power(operand_set_t op);
    power_t      res;
    logic [63:0] m;
    logic [63:0] sq;
    logic [63:0] acc;
    m = {32'd0, op.modulus};
    if (m == 64'd0) begin
      res.power = '0;
      res.bad   = 1'b1;
      return res;
    end
    sq  = {32'd0, op.base_value} % m;
    acc = 64'd1;
    for (int i = 0; i < WIDTH; i++) begin
      if (op.exponent[i]) acc = ((acc % m) * sq) % m;
      sq = (sq * sq) % m;
    end
    res.power = acc[WIDTH-1:0];
    res.bad   = 1'b0;
    return res;
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Operand with weight on small values and on values close to the maximum.
  function automatic logic [WIDTH-1:0] shaped_operand(int unsigned small_cap);
    case ($urandom_range(0, 9))
      0: return WIDTH'($urandom_range(0, small_cap));
      1: return '1 - WIDTH'($urandom_range(0, 3));
      default: return WIDTH'($urandom());
    endcase
  endfunction

  task automatic add_set(logic [WIDTH-1:0] b, logic [WIDTH-1:0] e, logic [WIDTH-1:0] m,
                         bit drain, bit quiet);
    operand_set_t s;
    s.base_value  = b;
    s.exponent    = e;
    s.modulus     = m;
    s.drain_first = drain;
    s.quiet       = quiet;
    s.gap         = quiet ? 0 : pick_gap();
    if (m == '0) zero_modulus_sets++;
    if (e == '0) zero_exponent_sets++;
    operand_sets = {operand_sets, s};
    total_sets++;
  endtask

  task automatic flag_mismatch(string what);
    $display("mismatch at result %0d: %s", results_checked, what);
    error_count++;
  endtask

  // Sender: offers queued operand sets, pausing as each set asks.
  always @(posedge clk) begin : sender
    bit fire;
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.base_value <= '0;
      in_ch.exponent   <= '0;
      in_ch.modulus    <= '0;
      sink_quiet       <= 1'b0;
      staged            = 1'b0;
      gap_left          = 0;
    end else begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) begin
        pending_powers = {pending_powers, mod_power(offered_set)};
        sets_sent++;
      end
      if (!(in_ch.valid && !fire)) begin
        if (!staged && operand_sets.size() != 0) begin
          staged_set = operand_sets.pop_front();
          staged     = 1'b1;
          gap_left   = staged_set.gap;
        end
        if (staged && gap_left == 0 &&
            !(staged_set.drain_first && pending_powers.size() != 0)) begin
          offered_set       = staged_set;
          staged            = 1'b0;
          in_ch.valid      <= 1'b1;
          in_ch.base_value <= staged_set.base_value;
          in_ch.exponent   <= staged_set.exponent;
          in_ch.modulus    <= staged_set.modulus;
          sink_quiet       <= staged_set.quiet;
        end else begin
          in_ch.valid <= 1'b0;
          if (staged && gap_left != 0) gap_left--;
        end
      end
    end
  end

  // Receiver: random stalls, none while the sender is in a quiet stretch.
  always @(posedge clk) begin : receiver
    int unsigned r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left    = 0;
    end else if (sink_quiet) begin
      out_ch.ready <= 1'b1;
      stall_left    = 0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        stall_left    = (r < 95) ? $urandom_range(0, 3) : $urandom_range(20, 200);
      end
    end
  end

  // Result checker: each result transfer against the oldest expectation.
  always @(posedge clk) begin : result_check
    power_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_powers.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %h bad=%b",
                                out_ch.power_result, out_ch.bad_modulus));
      end else begin
        want = pending_powers.pop_front();
        if (out_ch.power_result !== want.power)
          flag_mismatch($sformatf("power_result %h, expected %h",
                                  out_ch.power_result, want.power));
        if (out_ch.bad_modulus !== want.bad)
          flag_mismatch($sformatf("bad_modulus %b, expected %b",
                                  out_ch.bad_modulus, want.bad));
      end
      results_checked++;
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("[modular_exponentiation] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [WIDTH-1:0] b;
    logic [WIDTH-1:0] e;
    logic [WIDTH-1:0] m;
    rst_n <= 1'b0;

    // Directed sets: zero modulus, zero exponent, modulus one and operand extremes.
    add_set('0, '0, '0, 1'b0, 1'b0);
    add_set('1, '1, '0, 1'b0, 1'b0);
    add_set(32'd5, '0, 32'd1, 1'b0, 1'b0);
    add_set('0, '0, 32'd7, 1'b0, 1'b0);
    add_set('1, '0, '1, 1'b0, 1'b0);
    add_set('1, '1, 32'd1, 1'b0, 1'b0);
    add_set(32'd3, 32'd1, 32'd1, 1'b0, 1'b0);
    add_set('0, 32'd5, 32'd13, 1'b0, 1'b0);
    add_set(32'd2, 32'd10, 32'd1000, 1'b0, 1'b0);
    add_set('1, '1, '1, 1'b0, 1'b0);
    add_set(32'hFFFF_FFFE, '1, '1, 1'b0, 1'b0);
    add_set('1, 32'd1, 32'hFFFF_FFFE, 1'b0, 1'b0);
    add_set(32'd13, 32'd13, 32'd13, 1'b0, 1'b0);
    add_set(32'd2, 32'd31, '1, 1'b0, 1'b0);
    add_set('1, '1, 32'd2, 1'b0, 1'b0);
    add_set(32'd123456789, '1, 32'd4294967291, 1'b0, 1'b0);
    add_set(32'd7, 32'd1, '1, 1'b0, 1'b0);
    add_set(32'd1, '1, 32'd97, 1'b0, 1'b0);
    add_set('1, 32'd2, 32'h8000_0000, 1'b0, 1'b0);
    add_set(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 1'b0, 1'b0);
    add_set(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAB, 1'b0, 1'b0);

    // Random sets; the sender drains the block twice and keeps one stretch free of stalls.
    for (int i = 0; i < RANDOM_JOBS; i++) begin
      b = shaped_operand(20);
      e = shaped_operand(8);
      if ($urandom_range(0, 29) == 0) m = '0;
      else m = shaped_operand(20);
      add_set(b, e, m, (i == 0) || (i == 70), (i >= 100) && (i < 120));
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (sets_sent < total_sets || pending_powers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d operand sets (%0d with zero modulus, %0d with zero exponent)",
             sets_sent, zero_modulus_sets, zero_exponent_sets);
    $display("checked %0d results under random sender gaps and receiver stalls",
             results_checked);
    if (error_count == 0) begin
      $display("[modular_exponentiation] OK");
    end else begin
      $display("[modular_exponentiation] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/mexp_pkg.sv
rtl/mexp_if.sv
rtl/mexp_dp.sv
rtl/mexp_ctrl.sv
rtl/modular_exponentiation.sv
tb/sv/tb.sv
